@@ sv/dcpp_pkg.sv @@
// Package for the Dubins arc pose propagation core.
// Fixed widths, the CORDIC angle table and shared constants; no dependencies.
package dcpp_pkg;

  localparam int unsigned TrigStagesDef = 16;
  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned AtanEntries   = 24;

  localparam logic [63:0] TurnQ32      = 64'd683565276;
  localparam logic [63:0] TaylorMagMax = 64'd17179869;
  localparam logic [63:0] CordicGainQ30 = 64'd652032874;

  typedef logic [31:0] atan_tbl_t [AtanEntries];
  localparam atan_tbl_t AtanTurnQ32 = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic [15:0]        start_heading;
    logic [23:0]        len_first;
    logic [23:0]        len_second;
    logic [23:0]        len_third;
    logic signed [23:0] curv_first;
    logic signed [23:0] curv_second;
    logic signed [23:0] curv_third;
  } dcpp_in_t;

  typedef struct packed {
    logic signed [31:0] end1_x;
    logic signed [31:0] end1_y;
    logic [15:0]        end1_heading;
    logic signed [31:0] end2_x;
    logic signed [31:0] end2_y;
    logic [15:0]        end2_heading;
    logic signed [31:0] end3_x;
    logic signed [31:0] end3_y;
    logic [15:0]        end3_heading;
    logic [25:0]        total_length;
  } dcpp_out_t;

  // Arithmetic behavior as evaluated per arc; kept as functions so each
  // pipeline stage calls only its own slice.
  function automatic logic signed [63:0] floor_shr(input logic signed [63:0] v,
                                                   input int unsigned n);
    floor_shr = v >>> n;
  endfunction

  function automatic logic signed [63:0] round_shr(input logic signed [63:0] v,
                                                   input int unsigned n);
    logic [63:0] half;
    logic [63:0] av;
    half = 64'd1 << (n - 1);
    if (!v[63]) begin
      round_shr = $signed((v + half) >> n);
    end else begin
      av = -v;
      round_shr = -$signed((av + half) >> n);
    end
  endfunction

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 64'sd2147483647;
    else if (v < -64'sd2147483648) sat32 = -64'sd2147483648;
    else sat32 = v;
  endfunction

endpackage

@@ sv/dcpp_if.sv @@
// Valid/ready channel interface carrying a generic payload.
// Depends on dcpp_pkg for payload types at instantiation.
interface dcpp_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/dcpp_cordic.sv @@
// Pipelined rotation-mode CORDIC with a stall enable, one stage per register.
// Carries a side payload alongside; depends on dcpp_pkg.
module dcpp_cordic import dcpp_pkg::*; #(
  parameter int unsigned TRIG_STAGES = TrigStagesDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef,
  parameter int unsigned SIDE_W      = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [31:0]              angle_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     valid_o,
  output logic signed [FRAC_BITS+2:0] cos_o,
  output logic signed [FRAC_BITS+2:0] sin_o,
  output logic [SIDE_W-1:0]        side_o
);
  localparam int unsigned W = FRAC_BITS + 3;
  localparam int unsigned N = (TRIG_STAGES < AtanEntries) ? TRIG_STAGES : AtanEntries;
  localparam logic [63:0] X0 = (CordicGainQ30 + (64'd1 << (29 - FRAC_BITS))) >>
                               (30 - FRAC_BITS);

  logic signed [W-1:0]  x_q [N+1];
  logic signed [W-1:0]  y_q [N+1];
  logic signed [32:0]   z_q [N+1];
  logic [1:0]           qd_q [N+1];
  logic                 v_q [N+1];
  logic [SIDE_W-1:0]    s_q [N+1];

  logic [1:0]  q0;
  logic [31:0] rr0;
  assign q0  = 2'((angle_i + 32'h2000_0000) >> 30);
  assign rr0 = angle_i - {q0, 30'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= W'(X0);
      y_q[0]  <= '0;
      z_q[0]  <= {rr0[31], rr0};
      qd_q[0] <= q0;
      s_q[0]  <= side_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [W-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][32]) begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - $signed({1'b0, AtanTurnQ32[i]});
        end else begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + $signed({1'b0, AtanTurnQ32[i]});
        end
        qd_q[i+1] <= qd_q[i];
        s_q[i+1]  <= s_q[i];
      end
    end
  end

  always_comb begin
    case (qd_q[N])
      2'd0: begin cos_o = x_q[N];  sin_o = y_q[N];  end
      2'd1: begin cos_o = -y_q[N]; sin_o = x_q[N];  end
      2'd2: begin cos_o = -x_q[N]; sin_o = -y_q[N]; end
      default: begin cos_o = y_q[N]; sin_o = -x_q[N]; end
    endcase
  end
  assign valid_o = v_q[N];
  assign side_o  = s_q[N];
endmodule

@@ sv/dcpp_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, with stall enable.
// Computes floor(num/den) with a side payload; depends on dcpp_pkg.
module dcpp_divider import dcpp_pkg::*; #(
  parameter int unsigned NUM_W  = 64,
  parameter int unsigned DEN_W  = 48,
  parameter int unsigned Q_W    = 18,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quot_o,
  output logic [SIDE_W-1:0] side_o
);
  // Quotient saturates at all ones; callers clamp well below that.
  localparam int unsigned RW = DEN_W + Q_W + 1;
  logic [RW-1:0]     r_q [Q_W+1];
  logic [NUM_W-1:0]  n_q [Q_W+1];
  logic [DEN_W-1:0]  d_q [Q_W+1];
  logic [Q_W-1:0]    qt_q [Q_W+1];
  logic              ov_q [Q_W+1];
  logic              v_q [Q_W+1];
  logic [SIDE_W-1:0] s_q [Q_W+1];

  // Quotient bits above Q_W are caught by an overflow check at the input.
  logic ovf;
  assign ovf = (num_i >> Q_W) >= NUM_W'(den_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else if (en_i) v_q[0] <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]  <= RW'(num_i >> Q_W);
      n_q[0]  <= num_i;
      d_q[0]  <= den_i;
      qt_q[0] <= '0;
      ov_q[0] <= ovf;
      s_q[0]  <= side_i;
    end
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_bit
    logic [RW-1:0] sh;
    assign sh = {r_q[i][RW-2:0], n_q[i][Q_W-1-i]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[i+1] <= 1'b0;
      else if (en_i) v_q[i+1] <= v_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (sh >= RW'(d_q[i])) begin
          r_q[i+1]  <= sh - RW'(d_q[i]);
          qt_q[i+1] <= {qt_q[i][Q_W-2:0], 1'b1};
        end else begin
          r_q[i+1]  <= sh;
          qt_q[i+1] <= {qt_q[i][Q_W-2:0], 1'b0};
        end
        n_q[i+1]  <= n_q[i];
        d_q[i+1]  <= d_q[i];
        ov_q[i+1] <= ov_q[i];
        s_q[i+1]  <= s_q[i];
      end
    end
  end

  assign valid_o = v_q[Q_W];
  assign quot_o  = ov_q[Q_W] ? '1 : qt_q[Q_W];
  assign side_o  = s_q[Q_W];
endmodule

@@ sv/dcpp_arc.sv @@
// One arc of the pose chain: turn angle, sinc, direction CORDIC and position update.
// Depends on dcpp_pkg, dcpp_cordic and dcpp_divider.
module dcpp_arc import dcpp_pkg::*; #(
  parameter int unsigned TRIG_STAGES = TrigStagesDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef,
  parameter int unsigned SIDE_W      = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  input  logic [47:0]        h_i,
  input  logic [23:0]        len_i,
  input  logic signed [23:0] k_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               valid_o,
  output logic signed [31:0] x_o,
  output logic signed [31:0] y_o,
  output logic [47:0]        h_o,
  output logic [SIDE_W-1:0]  side_o
);
  localparam int unsigned CW  = FRAC_BITS + 3;
  localparam logic signed [63:0] One = 64'sd1 << FRAC_BITS;
  // Payload carried through the sine and divider units.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [47:0]        h;
    logic [47:0]        delta;
    logic [47:0]        halfd;
    logic [23:0]        len;
    logic [47:0]        mag;
    logic               taylor;
    logic signed [FRAC_BITS+1:0] gt;
    logic [SIDE_W-1:0]  side;
  } arc_t;
  localparam int unsigned AW = $bits(arc_t);

  // Stage A: |k|*L
  logic        va_q;
  logic [47:0] mag_a_q;
  logic        neg_a_q;
  logic signed [31:0] xa_q, ya_q;
  logic [47:0] ha_q;
  logic [23:0] la_q;
  logic [SIDE_W-1:0] sa_q;
  logic [23:0] ak;
  assign ak = k_i[23] ? 24'(-k_i) : 24'(k_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (en_i) va_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_a_q <= ak * len_i;
      neg_a_q <= k_i[23];
      xa_q <= x_i; ya_q <= y_i; ha_q <= h_i; la_q <= len_i; sa_q <= side_i;
    end
  end

  // Stage B: partial products of the turn and the Taylor square
  logic        vb_q;
  logic [63:0] bh_q, bl_q, sq_q;
  arc_t        pb_q;
  logic        neg_b_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (en_i) vb_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bh_q <= 64'(mag_a_q[47:16]) * TurnQ32;
      bl_q <= (64'(mag_a_q[15:0]) * TurnQ32) >> 16;
      sq_q <= 64'(mag_a_q[24:0]) * 64'(mag_a_q[24:0]);
      neg_b_q <= neg_a_q;
      pb_q <= '{x: xa_q, y: ya_q, h: ha_q, delta: '0, halfd: '0, len: la_q,
                mag: mag_a_q, taylor: 64'(mag_a_q) <= TaylorMagMax, gt: '0,
                side: sa_q};
    end
  end

  // Stage C: turn sum, Taylor u2 and inner factor
  logic        vc_q;
  arc_t        pc_q;
  arc_t        pc_n;
  logic [31:0] sang_c_q;
  logic [48:0] b_c;
  logic [7:0]  u2_c_q;
  logic [FRAC_BITS:0] inner_c_q;
  logic signed [63:0] u2_n;
  logic [7:0]  u2p_n;
  logic [19:0] q20_n;
  assign b_c  = 49'(bh_q + bl_q);
  assign u2_n = $signed(sq_q >> (66 - FRAC_BITS));
  // u2 stays below 68 on the series branch; divide by 20 as *205 >> 12
  assign u2p_n = 8'(u2_n) + 8'd10;
  assign q20_n = 20'(u2p_n) * 20'd205;
  always_comb begin
    pc_n       = pb_q;
    pc_n.delta = neg_b_q ? -b_c[47:0] : b_c[47:0];
    pc_n.halfd = neg_b_q ? -b_c[48:1] : b_c[48:1];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else if (en_i) vc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pc_q      <= pc_n;
      sang_c_q  <= b_c[48:17];
      u2_c_q    <= u2_n[7:0];
      inner_c_q <= (FRAC_BITS+1)'(One - 64'(q20_n >> 12));
    end
  end

  // Stage D: Taylor product
  logic        vd_q;
  arc_t        pd_q;
  logic [FRAC_BITS+8:0] tp_d_q;
  logic [31:0] sang_d_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else if (en_i) vd_q <= vc_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pd_q     <= pc_q;
      tp_d_q   <= u2_c_q * inner_c_q;
      sang_d_q <= sang_c_q;
    end
  end

  // Stage E: Taylor result
  logic        ve_q;
  arc_t        pe_q;
  arc_t        pe_n;
  logic [31:0] sang_e_q;
  logic [FRAC_BITS+9:0] tsum;
  logic [7:0]  tsh;
  logic [17:0] t6;
  logic signed [63:0] g_tay;
  // floor(n / (6 * 2^F)) is floor((n >> F) / 6); divide by 6 as *171 >> 10
  assign tsum  = {1'b0, tp_d_q} + ((FRAC_BITS+10)'(3) << FRAC_BITS);
  assign tsh   = 8'(tsum >> FRAC_BITS);
  assign t6    = 18'(tsh) * 18'd171;
  assign g_tay = One - 64'(t6 >> 10);
  always_comb begin
    pe_n    = pd_q;
    pe_n.gt = (FRAC_BITS+2)'((g_tay > One) ? One : ((g_tay < -One) ? -One : g_tay));
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ve_q <= 1'b0;
    else if (en_i) ve_q <= vd_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pe_q     <= pe_n;
      sang_e_q <= sang_d_q;
    end
  end

  // Sine of the half turn
  logic              vs;
  logic signed [CW-1:0] sc_unused, sn;
  logic [AW-1:0]     ps_raw;
  arc_t              ps;
  dcpp_cordic #(.TRIG_STAGES(TRIG_STAGES), .FRAC_BITS(FRAC_BITS), .SIDE_W(AW)) u_sin (
    .clk_i, .rst_ni, .en_i, .valid_i(ve_q), .angle_i(sang_e_q), .side_i(pe_q),
    .valid_o(vs), .cos_o(sc_unused), .sin_o(sn), .side_o(ps_raw)
  );
  assign ps = arc_t'(ps_raw);

  // Stage F: set up the sinc division
  logic        vf_q;
  arc_t        pf_q;
  logic        sneg_f_q;
  logic [63:0] num_f_q;
  logic [CW-1:0] as_n;
  assign as_n = sn[CW-1] ? CW'(-sn) : CW'(sn);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf_q <= 1'b0;
    else if (en_i) vf_q <= vs;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pf_q     <= ps;
      sneg_f_q <= sn[CW-1] & (sc_unused == sc_unused);
      num_f_q  <= (64'(as_n) << 33) + 64'(ps.mag >> 1);
    end
  end

  localparam int unsigned QW = FRAC_BITS + 2;
  logic          vq;
  logic [QW-1:0] qv;
  logic [AW:0]   pq_raw;
  arc_t          pq;
  logic          sneg_q;
  dcpp_divider #(.NUM_W(64), .DEN_W(48), .Q_W(QW), .SIDE_W(AW+1)) u_div (
    .clk_i, .rst_ni, .en_i, .valid_i(vf_q), .num_i(num_f_q),
    .den_i(pf_q.taylor ? 48'd1 : pf_q.mag), .side_i({sneg_f_q, pf_q}),
    .valid_o(vq), .quot_o(qv), .side_o(pq_raw)
  );
  assign pq     = arc_t'(pq_raw[AW-1:0]);
  assign sneg_q = pq_raw[AW];

  // Stage G: pick sinc, scale the chord
  logic        vg_q;
  arc_t        pg_q;
  logic signed [63:0] lgp_g_q;
  logic signed [63:0] g_sel;
  logic signed [63:0] qcl;
  always_comb begin
    qcl = ($signed({1'b0, 63'(qv)}) > One) ? One : $signed({1'b0, 63'(qv)});
    if (pq.taylor) g_sel = 64'(pq.gt);
    else g_sel = sneg_q ? -qcl : qcl;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vg_q <= 1'b0;
    else if (en_i) vg_q <= vq;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pg_q    <= pq;
      lgp_g_q <= $signed({1'b0, pq.len}) * $signed(g_sel[FRAC_BITS+1:0]);
    end
  end

  // Stage H: chord round, launch the direction CORDIC
  logic        vh_q;
  arc_t        ph_q;
  logic signed [63:0] lg_h_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vh_q <= 1'b0;
    else if (en_i) vh_q <= vg_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q   <= pg_q;
      lg_h_q <= round_shr(lgp_g_q, FRAC_BITS);
    end
  end

  logic [47:0] phi;
  assign phi = ph_q.h + ph_q.halfd;
  localparam int unsigned DW = AW + 64;
  logic              vr;
  logic signed [CW-1:0] cr, sr;
  logic [DW-1:0]     pr_raw;
  arc_t              pr;
  logic signed [63:0] lg_r;
  dcpp_cordic #(.TRIG_STAGES(TRIG_STAGES), .FRAC_BITS(FRAC_BITS), .SIDE_W(DW)) u_dir (
    .clk_i, .rst_ni, .en_i, .valid_i(vh_q), .angle_i(phi[47:16]),
    .side_i({lg_h_q, ph_q}), .valid_o(vr), .cos_o(cr), .sin_o(sr), .side_o(pr_raw)
  );
  assign pr   = arc_t'(pr_raw[AW-1:0]);
  assign lg_r = $signed(pr_raw[DW-1:AW]);

  // Stage I: displacement products
  logic        vi_q;
  arc_t        pi_q;
  logic signed [63:0] dxp_q, dyp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vi_q <= 1'b0;
    else if (en_i) vi_q <= vr;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pi_q  <= pr;
      dxp_q <= $signed(lg_r[31:0]) * cr;
      dyp_q <= $signed(lg_r[31:0]) * sr;
    end
  end

  // Stage J: add and saturate
  logic        vj_q;
  logic signed [31:0] xj_q, yj_q;
  logic [47:0] hj_q;
  logic [SIDE_W-1:0] sj_q;
  logic signed [63:0] xs_n, ys_n;
  assign xs_n = sat32(64'(pi_q.x) + round_shr(dxp_q, FRAC_BITS));
  assign ys_n = sat32(64'(pi_q.y) + round_shr(dyp_q, FRAC_BITS));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vj_q <= 1'b0;
    else if (en_i) vj_q <= vi_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xj_q <= 32'(xs_n);
      yj_q <= 32'(ys_n);
      hj_q <= pi_q.h + pi_q.delta;
      sj_q <= pi_q.side;
    end
  end

  assign valid_o = vj_q;
  assign x_o     = xj_q;
  assign y_o     = yj_q;
  assign h_o     = hj_q;
  assign side_o  = sj_q;
endmodule

@@ sv/dubins_curve_pose_propagation_core.sv @@
// Dubins arc pose propagation: start pose plus three arcs in, three end poses out.
//
// Channels: in_if (sink) takes one start pose and three (length, curvature)
// arcs per beat; out_if (source) gives the pose after each arc and the total
// length per beat. One result beat per input beat, in order.
// Throughput: one beat per cycle while the output is not stalled. The path is
// three arc units in series (two CORDIC pipelines and one bit-per-stage sinc
// divider each), plus the output register.
// Stall: the whole pipeline advances only while the output register is free
// or being taken; in_ready is that same enable, so no beat is lost.
// Reset clears every valid bit; the pipeline is empty afterwards.
// Headings are carried internally as 48-bit turn fractions and rounded to
// 16 bits at the output.
module dubins_curve_pose_propagation_core import dcpp_pkg::*; #(
  parameter int unsigned TRIG_STAGES = TrigStagesDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  dcpp_if.sink   in_if,
  dcpp_if.source out_if
);
  dcpp_in_t  in_d;
  assign in_d = in_if.data;

  logic en;
  logic out_v_q;
  assign en = !out_v_q || out_if.ready;
  assign in_if.ready = en;

  typedef struct packed {
    logic [25:0] total;
    logic [47:0] len23;
    logic [47:0] k23;
    logic [31:0] e1x; logic [31:0] e1y; logic [15:0] e1h;
    logic [31:0] e2x; logic [31:0] e2y; logic [15:0] e2h;
  } side_t;
  localparam int unsigned SW = $bits(side_t);

  side_t s0, s1, s2, s3;
  logic [SW-1:0] r1, r2, r3;
  logic v1, v2, v3;
  logic signed [31:0] x1, y1, x2, y2, x3, y3;
  logic [47:0] h1, h2, h3;

  always_comb begin
    s0 = '0;
    s0.total = 26'(in_d.len_first) + 26'(in_d.len_second) + 26'(in_d.len_third);
    s0.len23 = {in_d.len_second, in_d.len_third};
    s0.k23   = {in_d.curv_second, in_d.curv_third};
  end

  dcpp_arc #(.TRIG_STAGES(TRIG_STAGES), .FRAC_BITS(FRAC_BITS), .SIDE_W(SW)) u_arc1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_if.valid && en),
    .x_i(in_d.start_x), .y_i(in_d.start_y), .h_i({in_d.start_heading, 32'd0}),
    .len_i(in_d.len_first), .k_i(in_d.curv_first), .side_i(s0),
    .valid_o(v1), .x_o(x1), .y_o(y1), .h_o(h1), .side_o(r1)
  );
  always_comb begin
    s1 = side_t'(r1);
    s1.e1x = x1; s1.e1y = y1; s1.e1h = 16'((h1 + 48'h8000_0000) >> 32);
  end
  dcpp_arc #(.TRIG_STAGES(TRIG_STAGES), .FRAC_BITS(FRAC_BITS), .SIDE_W(SW)) u_arc2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1),
    .x_i(x1), .y_i(y1), .h_i(h1),
    .len_i(s1.len23[47:24]), .k_i(s1.k23[47:24]), .side_i(s1),
    .valid_o(v2), .x_o(x2), .y_o(y2), .h_o(h2), .side_o(r2)
  );
  always_comb begin
    s2 = side_t'(r2);
    s2.e2x = x2; s2.e2y = y2; s2.e2h = 16'((h2 + 48'h8000_0000) >> 32);
  end
  dcpp_arc #(.TRIG_STAGES(TRIG_STAGES), .FRAC_BITS(FRAC_BITS), .SIDE_W(SW)) u_arc3 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2),
    .x_i(x2), .y_i(y2), .h_i(h2),
    .len_i(s2.len23[23:0]), .k_i(s2.k23[23:0]), .side_i(s2),
    .valid_o(v3), .x_o(x3), .y_o(y3), .h_o(h3), .side_o(r3)
  );
  assign s3 = side_t'(r3);

  dcpp_out_t out_d, out_q;
  always_comb begin
    out_d.end1_x = s3.e1x; out_d.end1_y = s3.e1y; out_d.end1_heading = s3.e1h;
    out_d.end2_x = s3.e2x; out_d.end2_y = s3.e2y; out_d.end2_heading = s3.e2h;
    out_d.end3_x = x3; out_d.end3_y = y3;
    out_d.end3_heading = 16'((h3 + 48'h8000_0000) >> 32);
    out_d.total_length = s3.total;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= v3;
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_if.valid = out_v_q;
  assign out_if.data  = out_q;
endmodule

@@ bench/dubins_curve_pose_propagation_core_test.sv @@
// Self-checking bench for the Dubins arc pose propagation core.
// Needs dcpp_pkg, dcpp_if and dubins_curve_pose_propagation_core; predicts every pose bit-exact.
module dubins_curve_pose_propagation_core_test;
  import dcpp_pkg::*;

  localparam int unsigned NumStages  = 16;
  localparam int unsigned Frac       = 16;
  localparam int unsigned DrainCycles = 220;
  localparam longint unsigned Mask32 = 64'hFFFF_FFFF;
  localparam longint unsigned Mask48 = 64'hFFFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dcpp_if #(.payload_t(dcpp_in_t))  pose_in ();
  dcpp_if #(.payload_t(dcpp_out_t)) pose_out ();

  dubins_curve_pose_propagation_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (pose_in),
    .out_if (pose_out)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  dcpp_out_t pending_poses[$];
  int        mismatches = 0;
  int        sent_beats = 0;
  int        got_beats  = 0;
  bit        idle_on    = 1'b1;

  function automatic longint rnd_shr(input longint v, input int unsigned n);
    longint half;
    half = 64'sd1 <<< (n - 1);
    if (v >= 0) return (v + half) >>> n;
    return -((-v + half) >>> n);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void rotate_unit(input longint unsigned ang, output longint c,
                                      output longint s);
    longint unsigned a, q, rr;
    longint x, y, z, xs, ys;
    a  = ang & Mask32;
    q  = ((a + (64'd1 << 29)) >> 30) & 64'd3;
    rr = (a - (q << 30)) & Mask32;
    z  = (rr >= (64'd1 << 31)) ? longint'(rr) - (64'sd1 <<< 32) : longint'(rr);
    x  = (longint'(CordicGainQ30) + (64'sd1 <<< (29 - Frac))) >>> (30 - Frac);
    y  = 0;
    for (int i = 0; i < NumStages; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'({32'd0, AtanTurnQ32[i]});
      end else begin
        x = x + ys; y = y - xs; z = z + longint'({32'd0, AtanTurnQ32[i]});
      end
    end
    case (q)
      64'd0:   begin c = x;  s = y;  end
      64'd1:   begin c = -y; s = x;  end
      64'd2:   begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
  endfunction

  // Advance one pose along a constant-curvature arc; heading in 2^-48 turn.
  function automatic void follow_arc(inout longint px, inout longint py,
                                     inout longint unsigned ph,
                                     input longint unsigned len, input longint k);
    longint one, u2, inner, g, lg, c, s, sn, cs;
    longint unsigned ak, mag, b, half, delta, halfd, phi, as, qv;
    one  = 64'sd1 <<< Frac;
    ak   = (k < 0) ? longint'(-k) : longint'(k);
    mag  = ak * len;
    b    = (mag >> 16) * TurnQ32 + (((mag & 64'hFFFF) * TurnQ32) >> 16);
    half = b >> 1;
    if (k < 0) begin
      delta = (64'd0 - b) & Mask48; halfd = (64'd0 - half) & Mask48;
    end else begin
      delta = b & Mask48; halfd = half & Mask48;
    end
    if (mag <= TaylorMagMax) begin
      u2    = longint'((mag * mag) >> (66 - Frac));
      inner = one - (u2 + 10) / 20;
      g     = one - (u2 * inner + 3 * one) / (6 * one);
    end else begin
      rotate_unit(half >> 16, cs, sn);
      as = (sn < 0) ? longint'(-sn) : longint'(sn);
      qv = ((as << 33) + (mag >> 1)) / mag;
      if (qv > longint'(one)) qv = one;
      g = (sn < 0) ? -longint'(qv) : longint'(qv);
    end
    if (g > one) g = one;
    if (g < -one) g = -one;
    phi = (ph + halfd) & Mask48;
    rotate_unit(phi >> 16, c, s);
    lg = rnd_shr(longint'(len) * g, Frac);
    px = clamp32(px + rnd_shr(lg * c, Frac));
    py = clamp32(py + rnd_shr(lg * s, Frac));
    ph = (ph + delta) & Mask48;
  endfunction

  function automatic logic [15:0] round_heading(input longint unsigned h);
    return 16'(((h + (64'd1 << 31)) >> 32) & 64'hFFFF);
  endfunction

  function automatic dcpp_out_t propagate_path(input dcpp_in_t p);
    dcpp_out_t r;
    longint x, y;
    longint unsigned h;
    x = p.start_x;
    y = p.start_y;
    h = longint'({48'd0, p.start_heading}) << 32;
    follow_arc(x, y, h, {40'd0, p.len_first}, p.curv_first);
    r.end1_x = 32'(x); r.end1_y = 32'(y); r.end1_heading = round_heading(h);
    follow_arc(x, y, h, {40'd0, p.len_second}, p.curv_second);
    r.end2_x = 32'(x); r.end2_y = 32'(y); r.end2_heading = round_heading(h);
    follow_arc(x, y, h, {40'd0, p.len_third}, p.curv_third);
    r.end3_x = 32'(x); r.end3_y = 32'(y); r.end3_heading = round_heading(h);
    r.total_length = 26'(p.len_first) + 26'(p.len_second) + 26'(p.len_third);
    return r;
  endfunction

  function automatic int draw_gap();
    return idle_on ? $urandom_range(0, 12) : 0;
  endfunction

  task automatic send_path(input dcpp_in_t p);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      pose_in.valid <= 1'b0;
    end
    @(negedge clk_i);
    pose_in.valid <= 1'b1;
    pose_in.data  <= p;
    do @(posedge clk_i); while (!pose_in.ready);
    pending_poses.push_back(propagate_path(p));
    sent_beats++;
  endtask

  task automatic send_fields(input longint sx, input longint sy, input int hd,
                             input int l1, input int l2, input int l3,
                             input int k1, input int k2, input int k3);
    dcpp_in_t p;
    p.start_x = 32'(sx); p.start_y = 32'(sy); p.start_heading = 16'(hd);
    p.len_first = 24'(l1); p.len_second = 24'(l2); p.len_third = 24'(l3);
    p.curv_first = 24'(k1); p.curv_second = 24'(k2); p.curv_third = 24'(k3);
    send_path(p);
  endtask

  task automatic check_field(input string name, input longint e, input longint g);
    if (e != g) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch beat %0d %s: expected %0d got %0d", got_beats, name, e, g);
    end
  endtask

  // Output side: random back-pressure, check every beat taken.
  initial begin
    dcpp_out_t exp_pose, got;
    int gap;
    pose_out.ready = 1'b0;
    forever begin
      gap = draw_gap();
      repeat (gap) begin
        @(negedge clk_i);
        pose_out.ready <= 1'b0;
      end
      @(negedge clk_i);
      pose_out.ready <= 1'b1;
      do @(posedge clk_i); while (!(pose_out.valid && rst_ni));
      got = pose_out.data;
      if (pending_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %0d", got_beats);
      end else begin
        exp_pose = pending_poses.pop_front();
        check_field("end1_x", exp_pose.end1_x, got.end1_x);
        check_field("end1_y", exp_pose.end1_y, got.end1_y);
        check_field("end1_heading", exp_pose.end1_heading, got.end1_heading);
        check_field("end2_x", exp_pose.end2_x, got.end2_x);
        check_field("end2_y", exp_pose.end2_y, got.end2_y);
        check_field("end2_heading", exp_pose.end2_heading, got.end2_heading);
        check_field("end3_x", exp_pose.end3_x, got.end3_x);
        check_field("end3_y", exp_pose.end3_y, got.end3_y);
        check_field("end3_heading", exp_pose.end3_heading, got.end3_heading);
        check_field("total_length", exp_pose.total_length, got.total_length);
      end
      got_beats++;
    end
  end

  task automatic test_straight_and_still();
    send_fields(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_fields(64'sh10000, -64'sh20000, 16'h4000, 24'h010000, 24'h020000, 24'h030000, 0, 0, 0);
    send_fields(0, 0, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0);
    send_fields(0, 0, 16'h8000, 0, 0, 0, 24'h7FFFFF, -24'sh800000, 24'h000001);
  endtask

  task automatic test_turning_arcs();
    send_fields(0, 0, 0, 24'h010000, 24'h010000, 24'h010000, 24'h010000, -24'sh10000, 24'h010000);
    send_fields(0, 0, 16'h2000, 24'h03243F, 24'h03243F, 24'h03243F,
                24'h010000, 24'h010000, 24'h010000);
    send_fields(0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                24'h7FFFFF, -24'sh800000, 24'h7FFFFF);
    // curvature small enough to stay on the series branch
    send_fields(64'sh123456, 64'sh654321, 16'h1234, 24'h000100, 24'h000040, 24'h000200,
                24'h000100, -24'sh100, 24'h000001);
    send_fields(0, 0, 16'hC000, 24'h010000, 24'h008000, 24'h000800,
                24'h000004, 24'h000001, -24'sh000002);
    send_fields(-64'sh1000, 64'sh1000, 16'h7FFF, 24'h800000, 24'h400000, 24'h200000,
                -24'sh400000, 24'h200000, -24'sh000100);
  endtask

  task automatic test_position_saturation();
    send_fields(64'sh7FFFFFFF, 64'sh7FFFFFFF, 16'h2000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                0, 0, 0);
    send_fields(-64'sh80000000, -64'sh80000000, 16'hA000, 24'hFFFFFF, 24'h010000, 0,
                0, 24'h010000, 0);
    send_fields(64'sh7FFF0000, -64'sh7FFF0000, 16'hE000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                24'h000010, -24'sh000010, 24'h000010);
  endtask

  function automatic int pick_len(input bit wide);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return wide ? $urandom_range(0, 24'hFFFFFF) : 24'hFFFFFF;
      default: return wide ? $urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 24'h3FFFF);
    endcase
  endfunction

  function automatic int pick_curv(input bit wide);
    int r;
    case ($urandom_range(0, 7))
      0:       r = 0;
      1:       r = $urandom_range(0, 24'h1FF) - 24'h100;
      2:       r = $urandom_range(0, 1) ? 24'h7FFFFF : -24'sh800000;
      default: r = wide ? int'($urandom) : ($urandom_range(0, 24'h3FFFF) - 24'h20000);
    endcase
    return r;
  endfunction

  task automatic test_random_paths(input int count, input bit wide);
    longint sx, sy;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        sx = $urandom_range(0, 1) ? 64'sh7FFF0000 + $urandom_range(0, 16'hFFFF)
                                  : -64'sh80000000 + $urandom_range(0, 16'hFFFF);
        sy = int'($urandom);
      end else begin
        sx = int'($urandom);
        sy = int'($urandom);
      end
      send_fields(sx, sy, $urandom_range(0, 16'hFFFF), pick_len(wide), pick_len(wide),
                  pick_len(wide), pick_curv(wide), pick_curv(wide), pick_curv(wide));
    end
  endtask

  initial begin
    int waited;
    pose_in.valid = 1'b0;
    pose_in.data  = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    test_straight_and_still();
    test_turning_arcs();
    test_position_saturation();
    test_random_paths(450, 1'b0);
    idle_on = 1'b0;
    test_random_paths(200, 1'b1);
    idle_on = 1'b1;
    test_random_paths(450, 1'b1);
    @(negedge clk_i);
    pose_in.valid <= 1'b0;
    waited = 0;
    while (pending_poses.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d paths: still, straight, turning, series-branch and saturating arcs",
             sent_beats);
    $display("with random gaps and back-pressure; %0d results checked, %0d mismatches",
             got_beats, mismatches);
    if (mismatches == 0 && pending_poses.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
